// File: rtl/core/mi3_pkg.sv
package mi3_pkg;

  // Field widths.
  localparam int InW    = 16;  // Q4.12 input entry
  localparam int ProdW  = 32;  // product of two inputs
  localparam int CrossW = 33;  // cross product entry, Q9.24
  localparam int DProdW = 49;  // cross entry times input
  localparam int DSumW  = 51;  // sum of three such products
  localparam int DMagW  = 50;  // determinant magnitude
  localparam int UnW    = 32;  // numerator magnitude
  localparam int ShiftW = 29;  // 28 fraction bits plus one for rounding
  localparam int RemW   = UnW + ShiftW;
  localparam int QBits  = 33;  // quotient bits of the doubled quotient
  localparam int OutW   = 32;

  // Pipeline depths.
  localparam int CrossLat = 2;
  localparam int DetLat   = 3;
  localparam int DivLat   = QBits + 2;
  localparam int DetOut   = CrossLat + DetLat;
  localparam int Latency  = DetOut + DivLat;

  typedef logic signed [InW-1:0]    q412_t;
  typedef logic signed [CrossW-1:0] cross_t;
  typedef logic signed [OutW-1:0]   q1616_t;

  // Determinant as the divider lanes need it.
  typedef struct packed {
    logic [DMagW-1:0] mag;
    logic             neg;
    logic             zero;
  } det_info_t;

endpackage

// File: rtl/core/mi3_cross.sv
module mi3_cross (
  input  logic             clk,
  input  logic             en,
  input  mi3_pkg::q412_t   col [3][3],
  output mi3_pkg::cross_t  rows [3][3],
  output mi3_pkg::q412_t   c2_out [3]
);

  logic signed [mi3_pkg::ProdW-1:0] pa [3][3];
  logic signed [mi3_pkg::ProdW-1:0] pb [3][3];
  mi3_pkg::q412_t                   c2_d [3];

  // Row i is the cross product of columns i+1 and i+2; first register the products.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pa[i][j] <= col[(i+1)%3][(j+1)%3] * col[(i+2)%3][(j+2)%3];
          pb[i][j] <= col[(i+1)%3][(j+2)%3] * col[(i+2)%3][(j+1)%3];
        end
        c2_d[i] <= col[2][i];
      end
    end
  end

  // Then the differences, exact in one extra bit.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          rows[i][j] <= mi3_pkg::CrossW'(pa[i][j]) - mi3_pkg::CrossW'(pb[i][j]);
        end
        c2_out[i] <= c2_d[i];
      end
    end
  end

endmodule

// File: rtl/core/mi3_det.sv
module mi3_det (
  input  logic               clk,
  input  logic               en,
  input  mi3_pkg::cross_t    rows_in [3][3],
  input  mi3_pkg::q412_t     c2 [3],
  output mi3_pkg::cross_t    rows_out [3][3],
  output mi3_pkg::det_info_t det
);

  logic signed [mi3_pkg::DProdW-1:0] dp [3];
  logic signed [mi3_pkg::DSumW-1:0]  dsum;
  mi3_pkg::cross_t                   rows_c [3][3];
  mi3_pkg::cross_t                   rows_d [3][3];

  // Products of row 2 of the adjugate with column 2.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        dp[j] <= rows_in[2][j] * c2[j];
      end
      rows_c <= rows_in;
    end
  end

  // Determinant sum.
  always_ff @(posedge clk) begin
    if (en) begin
      dsum <= mi3_pkg::DSumW'(dp[0]) + mi3_pkg::DSumW'(dp[1]) + mi3_pkg::DSumW'(dp[2]);
      rows_d <= rows_c;
    end
  end

  // Sign, magnitude and zero test; the magnitude stays below 2^48.
  always_ff @(posedge clk) begin
    if (en) begin
      det.neg  <= dsum[mi3_pkg::DSumW-1];
      det.zero <= (dsum == '0);
      det.mag  <= dsum[mi3_pkg::DSumW-1] ? mi3_pkg::DMagW'(-dsum)
                                         : mi3_pkg::DMagW'(dsum);
      rows_out <= rows_d;
    end
  end

endmodule

// File: rtl/core/mi3_div.sv
module mi3_div (
  input  logic               clk,
  input  logic               en,
  input  mi3_pkg::cross_t    num,
  input  mi3_pkg::det_info_t det,
  output mi3_pkg::q1616_t    quo
);

  localparam int NS = mi3_pkg::QBits;

  logic [mi3_pkg::RemW-1:0]  rem  [NS+1];
  logic [mi3_pkg::QBits-1:0] qb   [NS+1];
  logic [mi3_pkg::DMagW-1:0] ud   [NS+1];
  logic                      neg  [NS+1];
  logic                      ovf  [NS+1];
  logic                      sing [NS+1];

  logic [mi3_pkg::UnW-1:0]   un;
  logic [mi3_pkg::QBits:0]   tp;
  logic [mi3_pkg::QBits-1:0] q;
  logic                      pos_sat;
  logic                      neg_sat;

  // Numerator magnitude, doubled and scaled; a quotient of 2^33 or more saturates.
  assign un = num[mi3_pkg::CrossW-1] ? mi3_pkg::UnW'(-num) : mi3_pkg::UnW'(num);

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= {un, {mi3_pkg::ShiftW{1'b0}}};
      qb[0]   <= '0;
      ud[0]   <= det.mag;
      neg[0]  <= num[mi3_pkg::CrossW-1] ^ det.neg;
      ovf[0]  <= (mi3_pkg::RemW'(un) >> (mi3_pkg::QBits - mi3_pkg::ShiftW))
                 >= mi3_pkg::RemW'(det.mag);
      sing[0] <= det.zero;
    end
  end

  // Restoring division, one quotient bit per stage, most significant first.
  for (genvar s = 1; s <= NS; s++) begin : g_step
    localparam int K = NS - s;
    logic                     take;
    logic [mi3_pkg::RemW-1:0] dsh;

    assign take = (rem[s-1] >> K) >= mi3_pkg::RemW'(ud[s-1]);
    assign dsh  = mi3_pkg::RemW'(ud[s-1]) << K;

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s]  <= take ? rem[s-1] - dsh : rem[s-1];
        qb[s]   <= {qb[s-1][mi3_pkg::QBits-2:0], take};
        ud[s]   <= ud[s-1];
        neg[s]  <= neg[s-1];
        ovf[s]  <= ovf[s-1];
        sing[s] <= sing[s-1];
      end
    end
  end

  // Round half away from zero, then saturate and apply the sign; a zero determinant gives zero.
  assign tp      = {1'b0, qb[NS]} + 1'b1;
  assign q       = tp[mi3_pkg::QBits:1];
  assign pos_sat = ovf[NS] | q[32] | q[31];
  assign neg_sat = ovf[NS] | q[32] | (q[31] & (|q[30:0]));

  always_ff @(posedge clk) begin
    if (en) begin
      priority if (sing[NS]) begin
        quo <= '0;
      end else if (neg[NS]) begin
        quo <= neg_sat ? mi3_pkg::q1616_t'(32'h8000_0000)
                       : mi3_pkg::q1616_t'(-q[mi3_pkg::OutW-1:0]);
      end else begin
        quo <= pos_sat ? mi3_pkg::q1616_t'(32'h7FFF_FFFF)
                       : mi3_pkg::q1616_t'(q[mi3_pkg::OutW-1:0]);
      end
    end
  end

endmodule

// File: rtl/core/matrix3_inverse_core.sv
// Throughput: one matrix per cycle while the output is not stalled; the depth
// is set mostly by the divider's 33 step stages, one quotient bit per stage, in
// each of the nine lanes.
// A stall at the output freezes every stage at once, so nothing is lost.
// Reset clears only the valid bits; data registers are not reset.
module matrix3_inverse_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  mi3_pkg::q412_t         m_r0c0,
  input  mi3_pkg::q412_t         m_r1c0,
  input  mi3_pkg::q412_t         m_r2c0,
  input  mi3_pkg::q412_t         m_r0c1,
  input  mi3_pkg::q412_t         m_r1c1,
  input  mi3_pkg::q412_t         m_r2c1,
  input  mi3_pkg::q412_t         m_r0c2,
  input  mi3_pkg::q412_t         m_r1c2,
  input  mi3_pkg::q412_t         m_r2c2,
  output logic                   out_valid,
  input  logic                   out_ready,
  output mi3_pkg::q1616_t        inv_r0c0,
  output mi3_pkg::q1616_t        inv_r0c1,
  output mi3_pkg::q1616_t        inv_r0c2,
  output mi3_pkg::q1616_t        inv_r1c0,
  output mi3_pkg::q1616_t        inv_r1c1,
  output mi3_pkg::q1616_t        inv_r1c2,
  output mi3_pkg::q1616_t        inv_r2c0,
  output mi3_pkg::q1616_t        inv_r2c1,
  output mi3_pkg::q1616_t        inv_r2c2,
  output logic                   singular
);

  logic                        en;
  logic [mi3_pkg::Latency-1:0] vld;
  logic [mi3_pkg::DivLat-1:0]  sing_pipe;
  mi3_pkg::q412_t              col [3][3];
  mi3_pkg::cross_t             rows_b [3][3];
  mi3_pkg::q412_t              c2_b [3];
  mi3_pkg::cross_t             rows_e [3][3];
  mi3_pkg::det_info_t          det;
  mi3_pkg::q1616_t             quo [3][3];

  // The whole pipeline moves unless the final result is held.
  assign en        = !vld[mi3_pkg::Latency-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[mi3_pkg::Latency-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[mi3_pkg::Latency-2:0], in_valid};
    end
  end

  // Columns of the incoming matrix.
  assign col[0][0] = m_r0c0;
  assign col[0][1] = m_r1c0;
  assign col[0][2] = m_r2c0;
  assign col[1][0] = m_r0c1;
  assign col[1][1] = m_r1c1;
  assign col[1][2] = m_r2c1;
  assign col[2][0] = m_r0c2;
  assign col[2][1] = m_r1c2;
  assign col[2][2] = m_r2c2;

  mi3_cross u_cross (
    .clk    (clk),
    .en     (en),
    .col    (col),
    .rows   (rows_b),
    .c2_out (c2_b)
  );

  mi3_det u_det (
    .clk      (clk),
    .en       (en),
    .rows_in  (rows_b),
    .c2       (c2_b),
    .rows_out (rows_e),
    .det      (det)
  );

  // Nine divider lanes, one per entry of the inverse.
  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      mi3_div u_div (
        .clk (clk),
        .en  (en),
        .num (rows_e[i][j]),
        .det (det),
        .quo (quo[i][j])
      );
    end
  end

  // Singular flag follows the divider lanes.
  always_ff @(posedge clk) begin
    if (en) begin
      sing_pipe <= {sing_pipe[mi3_pkg::DivLat-2:0], det.zero};
    end
  end

  assign singular = sing_pipe[mi3_pkg::DivLat-1];
  assign inv_r0c0 = quo[0][0];
  assign inv_r0c1 = quo[0][1];
  assign inv_r0c2 = quo[0][2];
  assign inv_r1c0 = quo[1][0];
  assign inv_r1c1 = quo[1][1];
  assign inv_r1c2 = quo[1][2];
  assign inv_r2c0 = quo[2][0];
  assign inv_r2c1 = quo[2][1];
  assign inv_r2c2 = quo[2][2];

endmodule

// File: rtl/core/mi3_checker.sv
module mi3_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic                   singular,
  input mi3_pkg::q1616_t        inv_r0c0,
  input mi3_pkg::q1616_t        inv_r1c1,
  input mi3_pkg::q1616_t        inv_r2c2
);

  // A held result keeps its flag and its r0c0 entry.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(singular) && $stable(inv_r0c0))
    else $error("held result changed");

  // A singular result carries zero diagonal entries.
  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && singular |-> inv_r0c0 == '0 && inv_r1c1 == '0 && inv_r2c2 == '0)
    else $error("singular result has nonzero entries");

  // The pipeline takes a request whenever the output is free or being taken.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output side");

  // Nothing comes out straight after reset.
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result shown after reset");

endmodule

bind matrix3_inverse_core mi3_checker u_mi3_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .singular  (singular),
  .inv_r0c0  (inv_r0c0),
  .inv_r1c1  (inv_r1c1),
  .inv_r2c2  (inv_r2c2)
);
